/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// condition holds in the same cycle
`define CHECK_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");
// condition holds in the next cycle
`define CHECK_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`endif

/* hdl/qes_pkg.sv */
package qes_pkg;
  localparam int CoefW = 32;
  localparam int TolW = 24;
  localparam logic [TolW-1:0] TolReset = 24'd167;
  localparam int FracW = 24;
  localparam int RootW = 56;
  localparam int DiscW = 66;
  localparam int SqrtW = DiscW / 2;
  localparam int NumW = 35;
  localparam int DenW = 33;
  localparam int QuotW = 59;
  localparam logic [QuotW-1:0] PosLim = {{(QuotW-RootW+1){1'b0}}, {(RootW-1){1'b1}}};
  localparam logic [QuotW-1:0] NegLim = PosLim + 1'b1;

  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_TWO = 2'd2;
  localparam logic [1:0] COUNT_INF = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LIN,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] c;
  } front_t;

  typedef struct packed {
    kind_t kind;
    logic neg;
  } tag_t;
endpackage

/* hdl/qes_sqrt.sv */
`include "assert_macros.svh"
module qes_sqrt #(
  parameter int RadW = qes_pkg::DiscW,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [RadW-1:0] rad_in,
  input  logic [PW-1:0] pay_in,
  output logic out_valid,
  output logic [RadW/2-1:0] root_out,
  output logic [PW-1:0] pay_out
);
  import qes_pkg::*;
  localparam int N = RadW / 2;
  localparam int RemW = N + 2;

  logic [RadW-1:0] rad [0:N];
  logic [N-1:0] root [0:N];
  logic [RemW-1:0] rem [0:N];
  logic vld [0:N];
  logic [PW-1:0] pay [0:N];

  assign rad[0] = rad_in;
  assign root[0] = '0;
  assign rem[0] = '0;
  assign vld[0] = in_valid;
  assign pay[0] = pay_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic ge;
    always_comb begin
      rem_sh = {rem[i][RemW-3:0], rad[i][RadW-1 -: 2]};
      trial = {root[i], 2'b01};
      ge = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1] <= rad[i] << 2;
        root[i+1] <= {root[i][N-2:0], ge};
        rem[i+1] <= ge ? rem_sh - trial : rem_sh;
        pay[i+1] <= pay[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign root_out = root[N];
  assign pay_out = pay[N];

  `CHECK_IMPLY(a_rem_bound, clk, rst, vld[N], rem[N] <= {1'b0, root[N], 1'b0})
endmodule

/* hdl/qes_div.sv */
`include "assert_macros.svh"
module qes_div #(
  parameter int NW = qes_pkg::QuotW,
  parameter int DW = qes_pkg::DenW,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  input  logic [PW-1:0] pay_in,
  output logic out_valid,
  output logic [NW-1:0] quot_out,
  output logic [PW-1:0] pay_out
);
  import qes_pkg::*;

  logic [NW-1:0] nq [0:NW];
  logic [DW-1:0] den [0:NW];
  logic [DW-1:0] rem [0:NW];
  logic vld [0:NW];
  logic [PW-1:0] pay [0:NW];

  assign nq[0] = num_in;
  assign den[0] = den_in;
  assign rem[0] = '0;
  assign vld[0] = in_valid;
  assign pay[0] = pay_in;

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW:0] rsh;
    logic [DW:0] diff;
    logic ge;
    always_comb begin
      rsh = {rem[i], nq[i][NW-1]};
      diff = rsh - {1'b0, den[i]};
      ge = rsh >= {1'b0, den[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nq[i+1] <= {nq[i][NW-2:0], ge};
        rem[i+1] <= ge ? diff[DW-1:0] : rsh[DW-1:0];
        den[i+1] <= den[i];
        pay[i+1] <= pay[i];
      end
    end
  end

  assign out_valid = vld[NW];
  assign quot_out = nq[NW];
  assign pay_out = pay[NW];

  `CHECK_IMPLY(a_rem_below_den, clk, rst, vld[NW] && den[NW] != '0, rem[NW] < den[NW])
endmodule

/* hdl/quadratic_equation_solver.sv */
// quadratic_equation_solver: real roots of a*x^2 + b*x + c = 0
// input channel: in_valid/in_ready with coef_quadratic, coef_linear and
// coef_constant, all signed Q8.24
// output channel: out_valid/out_ready with root_count, root_first,
// root_second (signed Q32.24) and saturated
// config channel: cfg_valid/cfg_ready writes zero_tolerance from cfg_data;
// cfg_ready is always high, write only while no item is in flight
// throughput: one item per cycle unless the receiver stalls; the 33-stage square
// root pipeline and the two 59-stage divider pipelines each take a new item every cycle
// reset clears every valid bit and sets zero_tolerance to 167
// the whole pipeline advances only when the output register is empty or
// being taken; while the receiver stalls with a result held, in_ready is low
// and every stage keeps its item, so nothing is lost or repeated
module quadratic_equation_solver (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [qes_pkg::CoefW-1:0] coef_quadratic,
  input  logic [qes_pkg::CoefW-1:0] coef_linear,
  input  logic [qes_pkg::CoefW-1:0] coef_constant,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] root_count,
  output logic [qes_pkg::RootW-1:0] root_first,
  output logic [qes_pkg::RootW-1:0] root_second,
  output logic saturated,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [qes_pkg::TolW-1:0] cfg_data
);
  import qes_pkg::*;

  logic en;
  logic [TolW-1:0] zero_tolerance;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= TolReset;
    end else if (cfg_valid) begin
      zero_tolerance <= cfg_data;
    end
  end

  function automatic logic [CoefW-1:0] mag32(input logic [CoefW-1:0] x);
    mag32 = x[CoefW-1] ? ~x + 1'b1 : x;
  endfunction

  // stage 1: zero tests
  logic v1;
  logic [CoefW-1:0] a1, b1, c1;
  logic za1, zb1, zc1;
  logic [CoefW-1:0] tol_ext;
  assign tol_ext = {{(CoefW-TolW){1'b0}}, zero_tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= coef_quadratic;
      b1 <= coef_linear;
      c1 <= coef_constant;
      za1 <= mag32(coef_quadratic) <= tol_ext;
      zb1 <= mag32(coef_linear) <= tol_ext;
      zc1 <= mag32(coef_constant) <= tol_ext;
    end
  end

  // stage 2: products
  logic v2;
  logic [CoefW-1:0] a2, b2, c2;
  logic za2, zb2, zc2, acneg2;
  logic [2*CoefW-1:0] sq2, pr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;
      za2 <= za1;
      zb2 <= zb1;
      zc2 <= zc1;
      acneg2 <= a1[CoefW-1] ^ c1[CoefW-1];
      sq2 <= mag32(b1) * mag32(b1);
      pr2 <= mag32(a1) * mag32(c1);
    end
  end

  // stage 3: discriminant and case
  logic v3;
  front_t f3, f3_next;
  logic [DiscW-1:0] rad3, rad3_next;
  logic [DiscW-1:0] sq_ext, pr4, dsum, ddiff;

  always_comb begin
    sq_ext = {2'b00, sq2};
    pr4 = {pr2, 2'b00};
    dsum = sq_ext + pr4;
    ddiff = sq_ext - pr4;
    f3_next.a = a2;
    f3_next.b = b2;
    f3_next.c = c2;
    rad3_next = '0;
    if (za2) begin
      if (zb2) begin
        f3_next.kind = zc2 ? KIND_INF : KIND_NONE;
      end else begin
        f3_next.kind = KIND_LIN;
      end
    end else if (acneg2) begin
      f3_next.kind = (dsum == '0) ? KIND_ONE : KIND_TWO;
      rad3_next = dsum;
    end else if (sq_ext >= pr4) begin
      f3_next.kind = (ddiff == '0) ? KIND_ONE : KIND_TWO;
      rad3_next = ddiff;
    end else begin
      f3_next.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f3 <= f3_next;
      rad3 <= rad3_next;
    end
  end

  // square root pipeline
  logic vs;
  logic [SqrtW-1:0] root_s;
  front_t fs;
  logic [$bits(front_t)-1:0] fs_raw;
  assign fs = front_t'(fs_raw);

  qes_sqrt #(.RadW(DiscW), .PW($bits(front_t))) u_sqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v3),
    .rad_in(rad3),
    .pay_in(f3),
    .out_valid(vs),
    .root_out(root_s),
    .pay_out(fs_raw)
  );

  // stage 4: signed numerators and divisor
  logic v4;
  kind_t kind4;
  logic [NumW-1:0] num1_4, num2_4, num1_next, num2_next;
  logic [DenW-1:0] den4, den_next;
  logic [NumW-1:0] bx, cx, sx;

  always_comb begin
    bx = {{(NumW-CoefW){fs.b[CoefW-1]}}, fs.b};
    cx = {{(NumW-CoefW){fs.c[CoefW-1]}}, fs.c};
    sx = {{(NumW-SqrtW){1'b0}}, root_s};
    if (fs.kind == KIND_LIN) begin
      den_next = {fs.b[CoefW-1], fs.b};
      num1_next = -cx;
    end else begin
      den_next = {fs.a, 1'b0};
      num1_next = (fs.kind == KIND_TWO) ? -bx - sx : -bx;
    end
    num2_next = sx - bx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vs;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kind4 <= fs.kind;
      num1_4 <= num1_next;
      num2_4 <= num2_next;
      den4 <= den_next;
    end
  end

  // stage 5: magnitudes and rounding offset
  logic v5;
  tag_t tag5;
  logic neg2_5;
  logic [QuotW-1:0] nr1_5, nr2_5;
  logic [DenW-1:0] dmag5, dmag_next;
  logic [NumW-2:0] n1mag, n2mag;
  logic [NumW-1:0] n1abs, n2abs;
  logic [QuotW-1:0] half;

  always_comb begin
    dmag_next = den4[DenW-1] ? ~den4 + 1'b1 : den4;
    n1abs = num1_4[NumW-1] ? ~num1_4 + 1'b1 : num1_4;
    n2abs = num2_4[NumW-1] ? ~num2_4 + 1'b1 : num2_4;
    n1mag = n1abs[NumW-2:0];
    n2mag = n2abs[NumW-2:0];
    half = {{(QuotW-DenW+1){1'b0}}, dmag_next[DenW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tag5 <= '{kind: kind4, neg: num1_4[NumW-1] ^ den4[DenW-1]};
      neg2_5 <= num2_4[NumW-1] ^ den4[DenW-1];
      dmag5 <= dmag_next;
      nr1_5 <= {1'b0, n1mag, {FracW{1'b0}}} + half;
      nr2_5 <= {1'b0, n2mag, {FracW{1'b0}}} + half;
    end
  end

  // divider pipelines
  logic vd;
  logic [QuotW-1:0] q1, q2;
  logic [$bits(tag_t)-1:0] tagd_raw;
  tag_t tagd;
  logic neg2_d;
  assign tagd = tag_t'(tagd_raw);

  qes_div #(.NW(QuotW), .DW(DenW), .PW($bits(tag_t))) u_div_first (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v5),
    .num_in(nr1_5),
    .den_in(dmag5),
    .pay_in(tag5),
    .out_valid(vd),
    .quot_out(q1),
    .pay_out(tagd_raw)
  );

  qes_div #(.NW(QuotW), .DW(DenW), .PW(1)) u_div_second (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v5),
    .num_in(nr2_5),
    .den_in(dmag5),
    .pay_in(neg2_5),
    .out_valid(),
    .quot_out(q2),
    .pay_out(neg2_d)
  );

  // output stage: clip, sign and select
  logic [QuotW-1:0] lim1, lim2, qc1, qc2, sr1, sr2;
  logic sat1, sat2;
  logic [1:0] count_next;
  logic [RootW-1:0] first_next, second_next;
  logic sat_next;

  always_comb begin
    lim1 = tagd.neg ? NegLim : PosLim;
    lim2 = neg2_d ? NegLim : PosLim;
    sat1 = q1 > lim1;
    sat2 = q2 > lim2;
    qc1 = sat1 ? lim1 : q1;
    qc2 = sat2 ? lim2 : q2;
    sr1 = tagd.neg ? ~qc1 + 1'b1 : qc1;
    sr2 = neg2_d ? ~qc2 + 1'b1 : qc2;
    first_next = '0;
    second_next = '0;
    sat_next = 1'b0;
    unique case (tagd.kind)
      KIND_INF: begin
        count_next = COUNT_INF;
      end
      KIND_LIN, KIND_ONE: begin
        count_next = COUNT_ONE;
        first_next = sr1[RootW-1:0];
        sat_next = sat1;
      end
      KIND_TWO: begin
        count_next = COUNT_TWO;
        first_next = sr1[RootW-1:0];
        second_next = sr2[RootW-1:0];
        sat_next = sat1 || sat2;
      end
      default: begin
        count_next = COUNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      root_count <= count_next;
      root_first <= first_next;
      root_second <= second_next;
      saturated <= sat_next;
    end
  end

  logic out_no_root, out_has_root, roots_zero;
  assign out_no_root = root_count == COUNT_NONE || root_count == COUNT_INF;
  assign out_has_root = root_count == COUNT_ONE || root_count == COUNT_TWO;
  assign roots_zero = root_first == '0 && root_second == '0;

  `CHECK_NEXT(a_enter, clk, rst, in_valid && in_ready, v1)
  `CHECK_IMPLY(a_no_root_zero, clk, rst, out_valid && out_no_root, roots_zero)
  `CHECK_IMPLY(a_second_only_two, clk, rst, out_valid && root_count != COUNT_TWO, root_second == '0)
  `CHECK_IMPLY(a_sat_has_root, clk, rst, out_valid && saturated, out_has_root)
endmodule
